@@ rtl/core/earliest_free_server_dispatch_assert.svh @@
// Assertion macros for the earliest-free-server dispatcher
`ifndef EARLIEST_FREE_SERVER_DISPATCH_ASSERT_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_ASSERT_SVH

// same-cycle implication, disabled in reset
`define EFSD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define EFSD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/efsd_pkg.sv @@
// Types and constants shared by the earliest-free-server dispatcher
package efsd_pkg;

  localparam int CFG_AW = 4;

  localparam logic [1:0] REG_WINDOW_COUNT = 2'd0;
  localparam logic [1:0] REG_OPEN_TIME    = 2'd1;
  localparam logic [1:0] REG_CLOSE_TIME   = 2'd2;
  localparam logic [1:0] REG_SERVICE_CAP  = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_JOB   = 1'b1;

  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;

  localparam logic [7:0]  RST_WINDOW_COUNT = 8'd1;
  localparam logic [16:0] RST_OPEN_TIME    = 17'd28800;
  localparam logic [16:0] RST_CLOSE_TIME   = 17'd61200;
  localparam logic [9:0]  RST_SERVICE_CAP  = 10'd60;
  localparam logic [31:0] RST_FREE_AT      = 32'd28800;

  typedef struct packed {
    logic       opcode;
    logic [4:0] arrive_hour;
    logic [5:0] arrive_minute;
    logic [5:0] arrive_second;
    logic [9:0] service_minutes;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  server_index;
    logic [31:0] wait_seconds;
    logic [47:0] total_wait;
    logic [31:0] jobs_served;
  } out_item_t;

endpackage

@@ rtl/core/earliest_free_server_dispatch.sv @@
// Earliest-free-server dispatcher: free-time memory, scan, update and config port
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | start, busy, in_data                    | taken when start && !busy
//  result  | out_valid, out_data                     | one-cycle strobe, no stall
//  config  | psel, penable, pwrite, paddr, pwdata,   | APB write at access cycle,
//          | prdata, pready                          | pready tied high
//
// A job converts its arrival time and is rejected if it is past the close time.
// Else it does one memory read per enabled server through the single read port
// of the free-time memory, then the compare drain, end-time and wait calculation
// and write-back. A start item and reset both run a fill pass over every memory
// slot; busy stays high meanwhile. Results cannot be held off by the receiver.
`include "earliest_free_server_dispatch_assert.svh"

module earliest_free_server_dispatch #(
  parameter int MAX_SERVERS = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  efsd_pkg::in_item_t         in_data,
  output logic                       out_valid,
  output efsd_pkg::out_item_t        out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [efsd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import efsd_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_SERVERS - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ARR   = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_CALC  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // fill pass runs on its own index through the write port; tracked by its own flag
  state_t          state_r, state_nxt;
  logic            clr_act_r;
  logic            clr_report_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic [31:0]     fill_val_r;

  logic [7:0]      wc_r;
  logic [16:0]     open_r;
  logic [16:0]     close_r;
  logic [9:0]      cap_r;

  in_item_t        job_r;
  logic [16:0]     arrive_r;
  logic [15:0]     svc_sec_r;
  logic [IDX_W-1:0] iss_idx_r;
  logic            rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [31:0]     best_val_r;
  logic [31:0]     wait_r;
  logic [31:0]     end_r;
  logic [47:0]     wait_sum_r;
  logic [31:0]     job_cnt_r;
  logic            out_valid_r;
  out_item_t       out_r;

  logic [31:0]     mem [MAX_SERVERS];
  logic [31:0]     rd_data_r;
  logic            mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [31:0]     mem_wd;

  logic [IDX_W-1:0] last_idx;
  logic            cfg_we;
  logic [16:0]     arrive_c;
  logic [9:0]      svc_min_c;
  logic [31:0]     base_c;
  logic [32:0]     end_sum_c;
  logic [48:0]     wsum_c;
  logic            accept;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign busy      = clr_act_r || (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_COUNT: prdata = {24'd0, wc_r};
      REG_OPEN_TIME:    prdata = {15'd0, open_r};
      REG_CLOSE_TIME:   prdata = {15'd0, close_r};
      REG_SERVICE_CAP:  prdata = {22'd0, cap_r};
      default:          prdata = 32'd0;
    endcase
  end

  // enabled count clamped to 1..MAX_SERVERS, as last index
  always_comb begin
    if (wc_r == 8'd0) begin
      last_idx = '0;
    end else if (32'(wc_r) >= 32'(MAX_SERVERS)) begin
      last_idx = LAST_SLOT;
    end else begin
      last_idx = IDX_W'(32'(wc_r) - 32'd1);
    end
  end

  always_comb begin
    arrive_c  = 17'(job_r.arrive_hour) * SEC_PER_HOUR
              + 17'(job_r.arrive_minute) * SEC_PER_MIN
              + 17'(job_r.arrive_second);
    svc_min_c = (job_r.service_minutes > cap_r) ? cap_r : job_r.service_minutes;
    base_c    = (best_val_r > {15'd0, arrive_r}) ? best_val_r : {15'd0, arrive_r};
    end_sum_c = {1'b0, base_c} + {17'd0, svc_sec_r};
    wsum_c    = {1'b0, wait_sum_r} + {17'd0, wait_r};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && in_data.opcode == OP_JOB) state_nxt = ST_ARR;
      ST_ARR:   state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (arrive_r > close_r) ? ST_IDLE : ST_SCAN;
      ST_SCAN:  if (iss_idx_r == last_idx) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // single write port: fill pass or job write-back
  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx_r;
    mem_wd = end_r;
    if (clr_act_r) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = fill_val_r;
    end else if (state_r == ST_DONE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[iss_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r    <= RST_WINDOW_COUNT;
      open_r  <= RST_OPEN_TIME;
      close_r <= RST_CLOSE_TIME;
      cap_r   <= RST_SERVICE_CAP;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_WINDOW_COUNT: wc_r    <= pwdata[7:0];
        REG_OPEN_TIME:    open_r  <= pwdata[16:0];
        REG_CLOSE_TIME:   close_r <= pwdata[16:0];
        REG_SERVICE_CAP:  cap_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clr_act_r    <= 1'b1;
      clr_report_r <= 1'b0;
      clr_idx_r    <= '0;
      fill_val_r   <= RST_FREE_AT;
      rd_vld_r     <= 1'b0;
      iss_idx_r    <= '0;
      wait_sum_r   <= '0;
      job_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;

      if (clr_act_r) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_SLOT) begin
          clr_act_r <= 1'b0;
          if (clr_report_r) begin
            out_valid_r <= 1'b1;
            out_r       <= '0;
          end
        end
      end

      // running minimum; strict compare keeps the lowest index on ties
      if (rd_vld_r && (rd_idx_r == '0 || rd_data_r < best_val_r)) begin
        best_idx_r <= rd_idx_r;
        best_val_r <= rd_data_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            job_r <= in_data;
            if (in_data.opcode == OP_START) begin
              clr_act_r    <= 1'b1;
              clr_report_r <= 1'b1;
              clr_idx_r    <= '0;
              fill_val_r   <= {15'd0, open_r};
              wait_sum_r   <= '0;
              job_cnt_r    <= '0;
            end
          end
        end
        ST_ARR: begin
          arrive_r  <= arrive_c;
          svc_sec_r <= 16'(svc_min_c) * 16'(SEC_PER_MIN);
        end
        ST_CHECK: begin
          iss_idx_r <= '0;
          if (arrive_r > close_r) begin
            out_valid_r         <= 1'b1;
            out_r.accepted      <= 1'b0;
            out_r.server_index  <= '0;
            out_r.wait_seconds  <= '0;
            out_r.total_wait    <= wait_sum_r;
            out_r.jobs_served   <= job_cnt_r;
          end
        end
        ST_SCAN: begin
          rd_vld_r  <= 1'b1;
          rd_idx_r  <= iss_idx_r;
          iss_idx_r <= iss_idx_r + IDX_W'(1);
        end
        ST_DRAIN: ;
        ST_CALC: begin
          wait_r <= (best_val_r > {15'd0, arrive_r}) ? best_val_r - {15'd0, arrive_r} : '0;
          end_r  <= end_sum_c[32] ? '1 : end_sum_c[31:0];
        end
        ST_DONE: begin
          wait_sum_r          <= wsum_c[48] ? '1 : wsum_c[47:0];
          job_cnt_r           <= (job_cnt_r == '1) ? job_cnt_r : job_cnt_r + 32'd1;
          out_valid_r         <= 1'b1;
          out_r.accepted      <= 1'b1;
          out_r.server_index  <= 7'(best_idx_r);
          out_r.wait_seconds  <= wait_r;
          out_r.total_wait    <= wsum_c[48] ? '1 : wsum_c[47:0];
          out_r.jobs_served   <= (job_cnt_r == '1) ? job_cnt_r : job_cnt_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // accesses never overlap: the write-back lands before the next item's scan
  `EFSD_ASSERT_NEXT(a_one_result_per_item, clk, rst_n, out_valid, !out_valid,
    "two results in consecutive cycles")
  `EFSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy,
    "item accepted but block not busy")
  `EFSD_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid && !out_data.accepted,
    out_data.server_index == 7'd0 && out_data.wait_seconds == 32'd0,
    "rejected item carries a server or a wait")
  `EFSD_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid && out_data.accepted,
    out_data.jobs_served != 32'd0, "accepted job with zero job count")
  `EFSD_ASSERT_NOW(a_best_in_range, clk, rst_n, state_r == ST_DONE,
    best_idx_r <= last_idx, "chosen server outside the enabled range")

endmodule
